// File: sv/hic_pkg.sv
// package for the hilbert index codec: beat types, stage type, config type and constants
`default_nettype none
package hic_pkg;

    localparam int MAX_DIMS_C      = 8;
    localparam int MAX_AXIS_BITS_C = 32;
    localparam int COORD_W         = 32;
    localparam int INDEX_W         = 64;
    localparam int DIMS_W          = 4;
    localparam int BITS_W          = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_AXIS = 1'b1;

    // conversion direction
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd2;
    localparam logic [BITS_W-1:0] BITS_RESET = 6'd16;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] index_in;
        logic [COORD_W-1:0] in_coord_0;
        logic [COORD_W-1:0] in_coord_1;
        logic [COORD_W-1:0] in_coord_2;
        logic [COORD_W-1:0] in_coord_3;
        logic [COORD_W-1:0] in_coord_4;
        logic [COORD_W-1:0] in_coord_5;
        logic [COORD_W-1:0] in_coord_6;
        logic [COORD_W-1:0] in_coord_7;
    } in_beat_t;

    typedef struct packed {
        logic               bad_setup;
        logic [INDEX_W-1:0] index_out;
        logic [COORD_W-1:0] out_coord_0;
        logic [COORD_W-1:0] out_coord_1;
        logic [COORD_W-1:0] out_coord_2;
        logic [COORD_W-1:0] out_coord_3;
        logic [COORD_W-1:0] out_coord_4;
        logic [COORD_W-1:0] out_coord_5;
        logic [COORD_W-1:0] out_coord_6;
        logic [COORD_W-1:0] out_coord_7;
    } out_beat_t;

    // transposed point traveling down the chain
    typedef struct packed {
        logic                                  func;
        logic [MAX_DIMS_C-1:0][COORD_W-1:0]    x;
    } stage_t;

    // shared configuration seen by every stage
    typedef struct packed {
        logic [DIMS_W-1:0] dims;
        logic [BITS_W-1:0] bits;
        logic              bad;
    } cfg_t;

endpackage
`default_nettype wire

// File: sv/hilbert_index_codec.sv
// top level of the hilbert index codec: config registers and the chain of level cells
// Converts a point of up to MAX_DIMS coordinates to its Hilbert index (func 0) or an
// index back to its point (func 1), with the axis count and bits per axis taken from
// two config registers. The registers are to be written only while the block is idle;
// the block itself does not enforce this. One beat is accepted every clock unless the
// output stalls; every beat passes through one input stage, one cell per bit level
// above 0 (MAX_AXIS_BITS - 1 cells, each doing the invert/swap step of its level for
// all used axes), a gray/excess stage and the output register. Cells walk the levels
// downward for encode and upward for decode. A setup with dims times bits above 64,
// or a value out of range, returns bad_setup with all other fields zero.
`default_nettype none
module hilbert_index_codec #(
    parameter int MAX_DIMS      = hic_pkg::MAX_DIMS_C,
    parameter int MAX_AXIS_BITS = hic_pkg::MAX_AXIS_BITS_C
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [hic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hic_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire hic_pkg::in_beat_t            in_beat,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output hic_pkg::out_beat_t                out_beat
);
    import hic_pkg::*;

    localparam int NUM_CELLS  = (MAX_AXIS_BITS > 1) ? MAX_AXIS_BITS - 1 : 1;
    localparam int NUM_STAGES = NUM_CELLS + 3;
    localparam int OCC_W      = $clog2(NUM_STAGES + 1) + 1;

    logic [DIMS_W-1:0] dims_reg;
    logic [BITS_W-1:0] bits_reg;
    cfg_t              cfg;
    logic [BITS_W+DIMS_W-1:0] span;

    logic   [NUM_CELLS:0] chain_valid;
    logic   [NUM_CELLS:0] chain_stall;
    stage_t               chain_data [NUM_CELLS+1];

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_RESET;
            bits_reg <= BITS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIMENSIONS:    dims_reg <= cfg_data[DIMS_W-1:0];
                REG_BITS_PER_AXIS: bits_reg <= cfg_data[BITS_W-1:0];
                default:           ;
            endcase
        end
    end

    // setup check
    assign span     = (BITS_W+DIMS_W)'(dims_reg) * (BITS_W+DIMS_W)'(bits_reg);
    assign cfg.dims = dims_reg;
    assign cfg.bits = bits_reg;
    assign cfg.bad  = (dims_reg == '0) || (int'(dims_reg) > MAX_DIMS)
                   || (bits_reg == '0) || (int'(bits_reg) > MAX_AXIS_BITS)
                   || (span > (BITS_W+DIMS_W)'(INDEX_W));

    hic_front #(
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .up_beat  (in_beat),
        .dn_valid (chain_valid[0]),
        .dn_stall (chain_stall[0]),
        .dn_data  (chain_data[0])
    );

    // one cell per bit level above 0
    for (genvar s = 0; s < NUM_CELLS; s++)
    begin : g_cell
        hic_cell #(
            .MAX_DIMS      (MAX_DIMS),
            .MAX_AXIS_BITS (MAX_AXIS_BITS),
            .STAGE         (s)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .up_valid (chain_valid[s]),
            .up_stall (chain_stall[s]),
            .up_data  (chain_data[s]),
            .dn_valid (chain_valid[s+1]),
            .dn_stall (chain_stall[s+1]),
            .dn_data  (chain_data[s+1])
        );
    end

    hic_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (chain_valid[NUM_CELLS]),
        .up_stall  (chain_stall[NUM_CELLS]),
        .up_data   (chain_data[NUM_CELLS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    // beats in flight
    always_comb
    begin
        occ_next = occ_reg;
        if (in_valid && !in_stall)
            occ_next = occ_next + OCC_W'(1);
        if (out_valid && !out_stall)
            occ_next = occ_next - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(NUM_STAGES))
        else $error("more beats in flight than stages");

    a_empty_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> !out_valid)
        else $error("result beat with nothing in flight");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.bad_setup |-> out_beat.index_out == '0
            && out_beat.out_coord_0 == '0 && out_beat.out_coord_7 == '0)
        else $error("bad setup beat carries data");

endmodule
`default_nettype wire

// File: sv/hic_front.sv
// input stage: masks coordinates for encode, unpacks and gray-decodes for decode
`default_nettype none
module hic_front #(
    parameter int MAX_DIMS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hic_pkg::cfg_t     cfg,
    input  wire logic              up_valid,
    output logic                   up_stall,
    input  wire hic_pkg::in_beat_t up_beat,
    output logic                   dn_valid,
    input  wire logic              dn_stall,
    output hic_pkg::stage_t        dn_data
);
    import hic_pkg::*;

    logic                               valid_reg;
    stage_t                             data_reg;
    stage_t                             data_next;
    logic [MAX_DIMS_C-1:0][COORD_W-1:0] raw;
    logic [MAX_DIMS_C-1:0][COORD_W-1:0] unpacked;
    logic [COORD_W-1:0]                 mask;
    logic                               advance;

    // coordinate fields as an array
    assign raw[0] = up_beat.in_coord_0;
    assign raw[1] = up_beat.in_coord_1;
    assign raw[2] = up_beat.in_coord_2;
    assign raw[3] = up_beat.in_coord_3;
    assign raw[4] = up_beat.in_coord_4;
    assign raw[5] = up_beat.in_coord_5;
    assign raw[6] = up_beat.in_coord_6;
    assign raw[7] = up_beat.in_coord_7;

    // mask of the used bits of one axis
    always_comb
    begin
        mask = '0;
        for (int k = 0; k < COORD_W; k++)
        begin
            if (k < int'(cfg.bits))
                mask[k] = 1'b1;
        end
    end

    // de-interleave the index, axis 0 on the high bit of each group
    always_comb
    begin
        unpacked = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            for (int k = 0; k < COORD_W; k++)
            begin
                for (int dd = 1; dd <= MAX_DIMS; dd++)
                begin
                    if (int'(cfg.dims) == dd && i < dd && k < int'(cfg.bits)
                        && dd * k + dd - 1 - i < INDEX_W)
                        unpacked[i][k] = up_beat.index_in[dd * k + dd - 1 - i];
                end
            end
        end
    end

    // select direction, gray decode uses the unpacked words before update
    always_comb
    begin
        data_next      = '0;
        data_next.func = up_beat.func;
        if (up_beat.func == FUNC_ENCODE)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                if (i < int'(cfg.dims))
                    data_next.x[i] = raw[i] & mask;
            end
        end
        else
        begin
            for (int i = 1; i < MAX_DIMS; i++)
            begin
                if (i < int'(cfg.dims))
                    data_next.x[i] = unpacked[i] ^ unpacked[i-1];
            end
            data_next.x[0] = unpacked[0];
            for (int dd = 1; dd <= MAX_DIMS; dd++)
            begin
                if (int'(cfg.dims) == dd)
                    data_next.x[0] = unpacked[0] ^ (unpacked[dd-1] >> 1);
            end
        end
    end

    // stage register
    assign advance  = !valid_reg || !dn_stall;
    assign up_stall = !advance;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// File: sv/hic_cell.sv
// one bit level of the invert/swap pass, ordered by direction
`default_nettype none
module hic_cell #(
    parameter int MAX_DIMS      = 8,
    parameter int MAX_AXIS_BITS = 32,
    parameter int STAGE         = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hic_pkg::cfg_t   cfg,
    input  wire logic            up_valid,
    output logic                 up_stall,
    input  wire hic_pkg::stage_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_stall,
    output hic_pkg::stage_t      dn_data
);
    import hic_pkg::*;

    localparam int ENC_LVL = (MAX_AXIS_BITS - 1 - STAGE > 0) ? MAX_AXIS_BITS - 1 - STAGE : 0;
    localparam int DEC_LVL = STAGE + 1;

    logic               valid_reg;
    stage_t             data_reg;
    stage_t             data_next;
    logic [BITS_W-1:0]  lvl;
    logic [COORD_W-1:0] q;
    logic [COORD_W-1:0] p;
    logic               active;
    logic               advance;

    // encode walks levels downward, decode upward
    assign lvl    = (up_data.func == FUNC_ENCODE) ? BITS_W'(ENC_LVL) : BITS_W'(DEC_LVL);
    assign q      = (lvl < BITS_W'(COORD_W)) ? (COORD_W'(1) << lvl) : '0;
    assign p      = q - COORD_W'(1);
    assign active = (lvl != '0) && (lvl < cfg.bits) && (lvl < BITS_W'(COORD_W));

    // swap or invert against axis 0, one axis after another
    always_comb
    begin
        logic [COORD_W-1:0] t;
        data_next = up_data;
        t         = '0;
        if (active)
        begin
            if (up_data.func == FUNC_ENCODE)
            begin
                for (int i = 0; i < MAX_DIMS; i++)
                begin
                    if (i < int'(cfg.dims))
                    begin
                        if ((data_next.x[i] & q) != '0)
                            data_next.x[0] = data_next.x[0] ^ p;
                        else
                        begin
                            t              = (data_next.x[0] ^ data_next.x[i]) & p;
                            data_next.x[0] = data_next.x[0] ^ t;
                            data_next.x[i] = data_next.x[i] ^ t;
                        end
                    end
                end
            end
            else
            begin
                for (int i = MAX_DIMS - 1; i >= 0; i--)
                begin
                    if (i < int'(cfg.dims))
                    begin
                        if ((data_next.x[i] & q) != '0)
                            data_next.x[0] = data_next.x[0] ^ p;
                        else
                        begin
                            t              = (data_next.x[0] ^ data_next.x[i]) & p;
                            data_next.x[0] = data_next.x[0] ^ t;
                            data_next.x[i] = data_next.x[i] ^ t;
                        end
                    end
                end
            end
        end
    end

    // stage register
    assign advance  = !valid_reg || !dn_stall;
    assign up_stall = !advance;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// File: sv/hic_back.sv
// output stages: gray, excess and interleave for encode only, then the result beat
`default_nettype none
module hic_back #(
    parameter int MAX_DIMS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hic_pkg::cfg_t   cfg,
    input  wire logic            up_valid,
    output logic                 up_stall,
    input  wire hic_pkg::stage_t up_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output hic_pkg::out_beat_t   out_beat
);
    import hic_pkg::*;

    logic               gray_valid_reg;
    stage_t             gray_reg;
    stage_t             gray_next;
    logic [COORD_W-1:0] excess_reg;
    logic [COORD_W-1:0] excess_next;
    logic [COORD_W-1:0] last;
    logic               gray_advance;

    logic               out_valid_reg;
    out_beat_t          out_reg;
    out_beat_t          out_next;
    stage_t             fin;
    logic [INDEX_W-1:0] h;
    logic               out_advance;

    // prefix xor over the axes for encode
    always_comb
    begin
        gray_next = up_data;
        if (up_data.func == FUNC_ENCODE)
        begin
            for (int i = 1; i < MAX_DIMS; i++)
            begin
                if (i < int'(cfg.dims))
                    gray_next.x[i] = gray_next.x[i] ^ gray_next.x[i-1];
            end
        end
    end

    // last used axis after gray encode
    always_comb
    begin
        last = '0;
        for (int dd = 1; dd <= MAX_DIMS; dd++)
        begin
            if (int'(cfg.dims) == dd)
                last = gray_next.x[dd-1];
        end
    end

    // excess bit j is the parity of the last axis above j within the level range
    always_comb
    begin
        logic acc;
        excess_next = '0;
        acc         = 1'b0;
        for (int j = COORD_W - 1; j >= 0; j--)
        begin
            excess_next[j] = acc;
            if (j >= 1 && j < int'(cfg.bits))
                acc = acc ^ last[j];
        end
    end

    assign gray_advance = !gray_valid_reg || out_advance;
    assign up_stall     = gray_valid_reg && !out_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gray_valid_reg <= 1'b0;
        else if (gray_advance)
            gray_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (gray_advance && up_valid)
        begin
            gray_reg   <= gray_next;
            excess_reg <= excess_next;
        end
    end

    // apply the excess to every used axis for encode
    always_comb
    begin
        fin = gray_reg;
        if (gray_reg.func == FUNC_ENCODE)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                if (i < int'(cfg.dims))
                    fin.x[i] = fin.x[i] ^ excess_reg;
            end
        end
    end

    // interleave, level-major with axis 0 on the high bit of each group
    always_comb
    begin
        h = '0;
        for (int dd = 1; dd <= MAX_DIMS; dd++)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                for (int k = 0; k < COORD_W; k++)
                begin
                    if (int'(cfg.dims) == dd && i < dd && k < int'(cfg.bits)
                        && dd * k + dd - 1 - i < INDEX_W)
                        h[dd * k + dd - 1 - i] = fin.x[i][k];
                end
            end
        end
    end

    // assemble the result beat
    always_comb
    begin
        out_next           = '0;
        out_next.bad_setup = cfg.bad;
        if (!cfg.bad)
        begin
            if (gray_reg.func == FUNC_ENCODE)
                out_next.index_out = h;
            else
            begin
                out_next.out_coord_0 = fin.x[0];
                out_next.out_coord_1 = fin.x[1];
                out_next.out_coord_2 = fin.x[2];
                out_next.out_coord_3 = fin.x[3];
                out_next.out_coord_4 = fin.x[4];
                out_next.out_coord_5 = fin.x[5];
                out_next.out_coord_6 = fin.x[6];
                out_next.out_coord_7 = fin.x[7];
            end
        end
    end

    // output register
    assign out_advance = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign out_beat    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_advance)
            out_valid_reg <= gray_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && gray_valid_reg)
            out_reg <= out_next;
    end

endmodule
`default_nettype wire
